// ----- rtl/mrf_pkg.sv -----
// Types and constants of the request framer: command, status and back-end
// state encodings shared by the front, queue, back and top level.
// No dependencies.
package mrf_pkg;

    localparam int FRAME_LENGTH = 8;
    localparam int FRAME_IDX_W  = $clog2(FRAME_LENGTH);

    localparam logic [7:0]  FC_WRITE   = 8'h01;
    localparam logic [7:0]  FC_READ    = 8'h02;
    localparam logic [15:0] READ_COUNT = 16'h0001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  ECHO_CRC   = 8'hFF;
    localparam logic [7:0]  ECHO_REG   = 8'hFE;
    localparam logic [7:0]  SLAVE_INIT = 8'h15;

    localparam logic [FRAME_IDX_W-1:0] CRC_HI_IDX = FRAME_IDX_W'(FRAME_LENGTH - 2);
    localparam logic [FRAME_IDX_W-1:0] CRC_LO_IDX = FRAME_IDX_W'(FRAME_LENGTH - 1);
    localparam logic [FRAME_IDX_W-1:0] FIRST_IDX  = '0;

    localparam logic [3:0] ECHO_POS   = 4'd2;
    localparam logic [3:0] DATA_POS   = 4'd5;
    localparam logic [3:0] REPLY_LAST = 4'(FRAME_LENGTH - 1);

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_REPLY = 2'd2,
        OP_NONE  = 2'd3
    } req_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_BAD_REG = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SEND   = 2'd1,
        BK_STATUS = 2'd2
    } back_state_t;

    typedef struct packed {
        req_op_t     op;
        logic [15:0] reg_addr;
        logic [15:0] data_value;
        logic [7:0]  rx_byte;
    } mrf_cmd_t;

    typedef struct packed {
        logic sending;
        logic awaiting;
    } back_stat_t;

endpackage

// ----- rtl/mrf_front.sv -----
// Front end: takes input transfers, drops unused codes, fills in the read
// word count and holds one classified command for the queue. Uses mrf_pkg.
module mrf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_req_type,
    input  logic [15:0]      in_reg_addr,
    input  logic [15:0]      in_data_value,
    input  logic [7:0]       in_rx_byte,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output mrf_pkg::mrf_cmd_t cmd
);
    import mrf_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    mrf_cmd_t  cmd_reg;
    mrf_cmd_t  cmd_next;
    req_op_t   op;
    logic      keep;

    assign op       = req_op_t'(in_req_type);
    assign keep     = (op != OP_NONE);
    assign in_ready = !vld_reg || cmd_ready;

    always_comb begin
        vld_next = vld_reg && !cmd_ready;
        cmd_next = cmd_reg;
        if (in_valid && in_ready && keep) begin
            vld_next            = 1'b1;
            cmd_next.op         = op;
            cmd_next.reg_addr   = in_reg_addr;
            cmd_next.data_value = (op == OP_READ) ? READ_COUNT : in_data_value;
            cmd_next.rx_byte    = in_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

endmodule

// ----- rtl/mrf_queue.sv -----
// Short command queue between the front and back ends.
// Uses mrf_pkg for the command type.
module mrf_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  mrf_pkg::mrf_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mrf_pkg::mrf_cmd_t pop_cmd
);
    import mrf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrf_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/mrf_back.sv -----
// Back end: builds and sends the frame with its CRC one byte per cycle while out_ready allows,
// collects reply bytes, reports status and resends on error. Uses mrf_pkg.
module mrf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          slave_address,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mrf_pkg::mrf_cmd_t   cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [7:0]          out_tx_byte,
    output logic [1:0]          out_status,
    output logic [7:0]          out_read_value,
    output logic                out_last,
    output mrf_pkg::back_stat_t stat
);
    import mrf_pkg::*;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    back_state_t             state_reg, state_next;
    logic [7:0]              frame_reg [FRAME_LENGTH];
    logic [7:0]              frame_next [FRAME_LENGTH];
    logic [FRAME_IDX_W-1:0]  idx_reg, idx_next;
    logic                    build_reg, build_next;
    logic [15:0]             crc_reg, crc_next;
    logic                    awaiting_reg, awaiting_next;
    logic [3:0]              count_reg, count_next;
    logic [7:0]              echo_reg, echo_next;
    logic [7:0]              data_reg, data_next;
    status_t                 st_reg, st_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    kind_reg, kind_next;
    logic [7:0]              tx_reg, tx_next;
    status_t                 status_reg, status_next;
    logic [7:0]              rv_reg, rv_next;
    logic                    last_reg, last_next;

    logic                    slot_free;
    logic                    pop;
    logic                    is_request;
    logic                    reply_final;
    logic [7:0]              send_byte;
    status_t                 reply_status;

    assign slot_free   = !m_valid_reg || out_ready;
    assign pop         = (state_reg == BK_IDLE) && cmd_valid;
    assign is_request  = (cmd.op == OP_WRITE) || (cmd.op == OP_READ);
    assign reply_final = pop && (cmd.op == OP_REPLY) && awaiting_reg
                         && (count_reg == REPLY_LAST);

    always_comb begin
        if (build_reg && (idx_reg == CRC_HI_IDX)) begin
            send_byte = crc_reg[15:8];
        end else if (build_reg && (idx_reg == CRC_LO_IDX)) begin
            send_byte = crc_reg[7:0];
        end else begin
            send_byte = frame_reg[idx_reg];
        end
    end

    always_comb begin
        if (echo_reg == frame_reg[2]) begin
            reply_status = ST_OK;
        end else if (echo_reg == ECHO_CRC) begin
            reply_status = ST_CRC_ERR;
        end else if (echo_reg == ECHO_REG) begin
            reply_status = ST_BAD_REG;
        end else begin
            reply_status = ST_UNKNOWN;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop && is_request) begin
                    state_next = BK_SEND;
                end else if (reply_final) begin
                    state_next = BK_STATUS;
                end
            end
            BK_SEND: begin
                if (slot_free && (idx_reg == CRC_LO_IDX)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_STATUS: begin
                if (slot_free) begin
                    state_next = (st_reg == ST_OK) ? BK_IDLE : BK_SEND;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        frame_next    = frame_reg;
        idx_next      = idx_reg;
        build_next    = build_reg;
        crc_next      = crc_reg;
        awaiting_next = awaiting_reg;
        count_next    = count_reg;
        echo_next     = echo_reg;
        data_next     = data_reg;
        st_next       = st_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        kind_next     = kind_reg;
        tx_next       = tx_reg;
        status_next   = status_reg;
        rv_next       = rv_reg;
        last_next     = last_reg;
        cmd_ready     = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                cmd_ready = 1'b1;
                if (pop && is_request) begin
                    frame_next[0] = slave_address;
                    frame_next[1] = (cmd.op == OP_WRITE) ? FC_WRITE : FC_READ;
                    frame_next[2] = cmd.reg_addr[15:8];
                    frame_next[3] = cmd.reg_addr[7:0];
                    frame_next[4] = cmd.data_value[15:8];
                    frame_next[5] = cmd.data_value[7:0];
                    crc_next      = CRC_INIT;
                    idx_next      = FIRST_IDX;
                    build_next    = 1'b1;
                    awaiting_next = 1'b1;
                    count_next    = '0;
                end else if (pop && (cmd.op == OP_REPLY) && awaiting_reg) begin
                    if (count_reg == ECHO_POS) begin
                        echo_next = cmd.rx_byte;
                    end
                    if (count_reg == DATA_POS) begin
                        data_next = cmd.rx_byte;
                    end
                    if (reply_final) begin
                        count_next = '0;
                        st_next    = reply_status;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            BK_SEND: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_TX;
                    tx_next      = send_byte;
                    status_next  = ST_OK;
                    rv_next      = '0;
                    last_next    = (idx_reg == CRC_LO_IDX);
                    idx_next     = idx_reg + 1'b1;
                    if (build_reg && (idx_reg < CRC_HI_IDX)) begin
                        crc_next = crc_feed(crc_reg, send_byte);
                    end
                    if (build_reg && (idx_reg == CRC_HI_IDX)) begin
                        frame_next[CRC_HI_IDX] = send_byte;
                    end
                    if (build_reg && (idx_reg == CRC_LO_IDX)) begin
                        frame_next[CRC_LO_IDX] = send_byte;
                    end
                end
            end
            BK_STATUS: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_STATUS;
                    tx_next      = '0;
                    status_next  = st_reg;
                    rv_next      = (st_reg == ST_OK) ? data_reg : '0;
                    last_next    = (st_reg == ST_OK);
                    if (st_reg == ST_OK) begin
                        awaiting_next = 1'b0;
                    end else begin
                        build_next = 1'b0;
                        idx_next   = FIRST_IDX;
                    end
                end
            end
            default: begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_valid_reg  <= 1'b0;
            awaiting_reg <= 1'b0;
            count_reg    <= '0;
            echo_reg     <= '0;
            data_reg     <= '0;
            crc_reg      <= CRC_INIT;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            awaiting_reg <= awaiting_next;
            count_reg    <= count_next;
            echo_reg     <= echo_next;
            data_reg     <= data_next;
            crc_reg      <= crc_next;
        end
        frame_reg  <= frame_next;
        idx_reg    <= idx_next;
        build_reg  <= build_next;
        st_reg     <= st_next;
        kind_reg   <= kind_next;
        tx_reg     <= tx_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
        last_reg   <= last_next;
    end

    assign out_valid      = m_valid_reg;
    assign out_kind       = kind_reg;
    assign out_tx_byte    = tx_reg;
    assign out_status     = status_reg;
    assign out_read_value = rv_reg;
    assign out_last       = last_reg;
    assign stat.sending   = (state_reg == BK_SEND);
    assign stat.awaiting  = awaiting_reg;

endmodule

// ----- rtl/modbus_request_framer.sv -----
// Top level of the request framer: slave address register, front end,
// command queue and back end. Uses mrf_pkg, mrf_front, mrf_queue, mrf_back.
//
//  channel  dir  handshake            content
//  s_       in   s_tvalid/s_tready    tuser req_type, tdata request or reply byte
//  m_       out  m_tvalid/m_tready    tuser kind, tdata byte/status, tlast
//  cfg_     in   cfg_valid/cfg_ready  slave address
//
// A request: the back end takes the command from the queue, then sends the
// 8 frame bytes, one per cycle while m_tready allows, folding the CRC in byte by byte;
// the eighth reply byte adds a status result and, on error, 8 resent bytes.
// The first frame byte passes the front register, the queue and the back-end output register.
// Reset is synchronous on aresetn low; no clearing pass is needed.
// The queue lets the front take items while the back end waits on m_tready.
module modbus_request_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic [39:0] s_tdata,   // [15:0] register_address, [31:16] data_value,
                                   // [39:32] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // [0] out_kind
    output logic [23:0] m_tdata,   // [7:0] tx_byte, [9:8] status, [17:10] read_value,
                                   // [23:18] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import mrf_pkg::*;

    logic       cfg_write;
    logic [7:0] slave_addr_reg;
    logic [7:0] slave_addr_next;
    logic       f_valid, f_ready;
    mrf_cmd_t   f_cmd;
    logic       q_valid, q_ready;
    mrf_cmd_t   q_cmd;
    logic       kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic [7:0] read_value;
    back_stat_t bk_stat;

    assign cfg_ready       = 1'b1;
    assign cfg_write       = cfg_valid && cfg_ready;
    assign slave_addr_next = cfg_write ? cfg_data : slave_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= SLAVE_INIT;
        end else begin
            slave_addr_reg <= slave_addr_next;
        end
    end

    mrf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_req_type   (s_tuser),
        .in_reg_addr   (s_tdata[15:0]),
        .in_data_value (s_tdata[31:16]),
        .in_rx_byte    (s_tdata[39:32]),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    mrf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .slave_address  (slave_addr_reg),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (kind),
        .out_tx_byte    (tx_byte),
        .out_status     (status),
        .out_read_value (read_value),
        .out_last       (m_tlast),
        .stat           (bk_stat)
    );

    assign m_tuser = kind;
    assign m_tdata = {6'b000000, read_value, status, tx_byte};

    a_tx_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_TX) |-> (m_tdata[17:8] == 10'd0))
        else $error("frame byte carries status or read value");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> (m_tlast == (m_tdata[9:8] == ST_OK)))
        else $error("status result last flag disagrees with status");

    a_more_bytes_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> bk_stat.sending)
        else $error("non-final result shown while back end is not sending");

    a_error_keeps_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) && !m_tlast |-> bk_stat.awaiting)
        else $error("error status without a pending exchange");

endmodule
